>>> design/bsch_pkg.sv
// Shared types, constants and the beat-step helper function of the beat scheduler.
package bsch_pkg;

    localparam int FRAC_BITS           = 16;
    localparam int BLOCK_MAX           = 4096;
    localparam int BAR_MAX_BEATS       = 16;
    localparam int MAX_BEATS_PER_BLOCK = 64;

    localparam int SPB_W     = 38;
    localparam int PHASE_W   = 39;
    localparam int ACC_W     = 39;
    localparam int NS_W      = 13;
    localparam int OFS_W     = 12;
    localparam int BEAT_W    = 4;
    localparam int BPB_W     = 5;
    localparam int CFG_IDX_W = 2;
    localparam int BCNT_W    = $clog2(MAX_BEATS_PER_BLOCK + 1);
    localparam int MOD_STEPS = PHASE_W;
    localparam int MOD_CNT_W = $clog2(MOD_STEPS + 1);

    localparam logic [SPB_W-1:0]  SPB_MIN       = SPB_W'(64 << FRAC_BITS);
    localparam logic [SPB_W-1:0]  SPB_RESET     = SPB_W'(1445068800);
    localparam logic [BPB_W-1:0]  BPB_RESET     = BPB_W'(4);
    localparam logic [BPB_W-1:0]  BPB_MAX       = BPB_W'(BAR_MAX_BEATS);
    localparam logic [NS_W-1:0]   BLOCK_LEN_MAX = NS_W'(BLOCK_MAX);
    localparam logic [BEAT_W-1:0] ACCENT_BEAT   = BEAT_W'(0);
    localparam logic [BEAT_W-1:0] COUNT_IN_BEAT = BEAT_W'(3);
    localparam logic [BCNT_W-1:0] BEATS_CAP     = BCNT_W'(MAX_BEATS_PER_BLOCK);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RUNNING,
        CFG_PLAYING,
        CFG_BPB,
        CFG_SPB
    } t_cfg_idx;

    typedef struct packed {
        logic              kind;
        logic [NS_W-1:0]   num_samples;
        logic [BEAT_W-1:0] start_beat;
    } t_in_item;

    typedef struct packed {
        logic [OFS_W-1:0]  beat_offset;
        logic [BEAT_W-1:0] beat_number;
        logic              click;
        logic              accent;
        logic              counted_in;
        logic              last;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WRAP,
        ST_EMIT,
        ST_ADVANCE
    } t_state;

    typedef enum logic {
        SRC_PHASE,
        SRC_ADVANCE
    } t_mod_src;

    typedef struct packed {
        logic     accept_bar;
        logic     load_item;
        logic     mod_start;
        t_mod_src mod_src;
        logic     fix;
        logic     emit;
        logic     store_phase;
    } t_cmd;

    typedef struct packed {
        logic in_bar;
        logic running;
        logic mod_done;
        logic have_beat;
        logic slot_free;
    } t_status;

    // Next beat number, (beat + 1) mod bpb, by restoring division on narrow values.
    function automatic logic [BEAT_W-1:0] step_beat(input logic [BEAT_W-1:0] beat,
                                                    input logic [BPB_W-1:0]  bpb);
        logic [2*BPB_W-1:0] x;
        logic [2*BPB_W-1:0] d;
        x = (2*BPB_W)'(beat) + (2*BPB_W)'(1);
        for (int i = BPB_W - 1; i >= 0; i--) begin
            d = (2*BPB_W)'(bpb) << i;
            if (x >= d) begin
                x = x - d;
            end
        end
        return x[BEAT_W-1:0];
    endfunction

endpackage

>>> design/bsch_mod.sv
// Bit-serial remainder unit: one restoring step per cycle.
module bsch_mod (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [bsch_pkg::PHASE_W-1:0] i_dividend,
    input  logic [bsch_pkg::SPB_W-1:0]   i_divisor,
    output logic [bsch_pkg::SPB_W-1:0]   o_remainder,
    output logic                        o_done
);
    import bsch_pkg::*;

    logic [PHASE_W-1:0]   r_dvd;
    logic [SPB_W-1:0]     r_dsr;
    logic [SPB_W-1:0]     r_rem;
    logic [MOD_CNT_W-1:0] r_cnt;
    logic                 r_done;

    logic [SPB_W:0] trial;
    logic [SPB_W:0] diff;
    logic           fits;
    logic [SPB_W-1:0] n_rem;

    always_comb begin
        trial = {r_rem, r_dvd[PHASE_W-1]};
        diff  = trial - {1'b0, r_dsr};
        fits  = trial >= {1'b0, r_dsr};
        n_rem = fits ? diff[SPB_W-1:0] : trial[SPB_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_cnt  <= MOD_CNT_W'(MOD_STEPS);
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == MOD_CNT_W'(1));
            if (r_cnt != '0) begin
                r_cnt <= r_cnt - MOD_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dsr <= i_divisor;
            r_rem <= '0;
        end else if (r_cnt != '0) begin
            r_dvd <= r_dvd << 1;
            r_rem <= n_rem;
        end
    end

    assign o_remainder = r_rem;
    assign o_done      = r_done;

endmodule

>>> design/bsch_dp.sv
// Datapath: configuration registers, beat phase, beat accumulator and result register.
module bsch_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bsch_pkg::t_in_item            i_in,
    input  logic                          i_cfg_we,
    input  logic [bsch_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bsch_pkg::SPB_W-1:0]     i_cfg_data,
    input  logic                          i_out_stall,
    input  bsch_pkg::t_cmd                i_cmd,
    output bsch_pkg::t_status             o_status,
    output bsch_pkg::t_out_item           o_out,
    output logic                          o_out_valid
);
    import bsch_pkg::*;

    logic                r_running;
    logic                r_playing;
    logic [BPB_W-1:0]    r_bpb;
    logic [SPB_W-1:0]    r_spb;
    logic [PHASE_W-1:0]  r_phase;
    logic [BEAT_W-1:0]   r_beat;
    logic                r_cin;
    logic                r_out_valid;
    t_out_item           r_out;
    logic [NS_W-1:0]     r_len;
    logic [SPB_W-1:0]    r_m;
    logic [ACC_W-1:0]    r_acc;
    logic [BCNT_W-1:0]   r_beats;

    logic [SPB_W-1:0]    spb_eff;
    logic [BPB_W-1:0]    bpb_eff;
    logic [NS_W-1:0]     blk_len;
    logic                phase_neg;
    logic [PHASE_W-1:0]  phase_mag;
    logic [PHASE_W-1:0]  mod_dvd;
    logic [SPB_W-1:0]    mod_rem;
    logic                mod_done;
    logic [SPB_W-1:0]    spb_minus_rem;
    logic [SPB_W-1:0]    n_m;
    logic [ACC_W-1:0]    n_acc_first;
    logic [ACC_W-1:0]    n_acc;
    logic                have_beat;
    logic                last_beat;
    logic                slot_free;
    logic                n_cin;
    logic [PHASE_W-1:0]  n_phase;

    always_comb begin
        spb_eff = (r_spb < SPB_MIN) ? SPB_MIN : r_spb;
        if (r_bpb == '0) begin
            bpb_eff = BPB_W'(1);
        end else if (r_bpb > BPB_MAX) begin
            bpb_eff = BPB_MAX;
        end else begin
            bpb_eff = r_bpb;
        end
        blk_len   = (i_in.num_samples > BLOCK_LEN_MAX) ? BLOCK_LEN_MAX : i_in.num_samples;
        phase_neg = r_phase[PHASE_W-1];
        phase_mag = phase_neg ? (~r_phase + PHASE_W'(1)) : r_phase;
        mod_dvd   = (i_cmd.mod_src == SRC_PHASE) ? phase_mag
                  : PHASE_W'(r_m) + (PHASE_W'(r_len) << FRAC_BITS);

        // Phase reduced into [0, L): a negative phase folds to L minus the remainder.
        // The first beat then lies at L - m, or at 0 when m is 0; L - m is the plain remainder for a negative phase.
        spb_minus_rem = spb_eff - mod_rem;
        if (mod_rem == '0) begin
            n_m         = '0;
            n_acc_first = '0;
        end else if (phase_neg) begin
            n_m         = spb_minus_rem;
            n_acc_first = ACC_W'(mod_rem);
        end else begin
            n_m         = mod_rem;
            n_acc_first = ACC_W'(spb_minus_rem);
        end

        n_acc     = r_acc + ACC_W'(spb_eff);
        have_beat = ((r_acc >> FRAC_BITS) < ACC_W'(r_len)) && (r_beats < BEATS_CAP);
        last_beat = ((n_acc >> FRAC_BITS) >= ACC_W'(r_len))
                  || (r_beats == BEATS_CAP - BCNT_W'(1));
        slot_free = !r_out_valid || !i_out_stall;
        n_cin     = r_cin || (r_beat == COUNT_IN_BEAT);

        // Back into [-L/2, L/2) for storage.
        if ((PHASE_W'(mod_rem) << 1) >= PHASE_W'(spb_eff)) begin
            n_phase = PHASE_W'(mod_rem) - PHASE_W'(spb_eff);
        end else begin
            n_phase = PHASE_W'(mod_rem);
        end
    end

    bsch_mod u_mod (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_cmd.mod_start),
        .i_dividend  (mod_dvd),
        .i_divisor   (spb_eff),
        .o_remainder (mod_rem),
        .o_done      (mod_done)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running   <= 1'b0;
            r_playing   <= 1'b0;
            r_bpb       <= BPB_RESET;
            r_spb       <= SPB_RESET;
            r_phase     <= '0;
            r_beat      <= '0;
            r_cin       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_RUNNING: begin
                        r_running <= i_cfg_data[0];
                        if (!i_cfg_data[0]) begin
                            r_phase <= '0;
                            r_beat  <= '0;
                            r_cin   <= 1'b0;
                        end
                    end
                    CFG_PLAYING: r_playing <= i_cfg_data[0];
                    CFG_BPB:     r_bpb     <= i_cfg_data[BPB_W-1:0];
                    CFG_SPB:     r_spb     <= i_cfg_data;
                endcase
            end
            if (i_cmd.accept_bar) begin
                r_phase <= '0;
                r_cin   <= 1'b0;
                r_beat  <= i_in.start_beat;
            end
            if (i_cmd.emit) begin
                r_beat <= step_beat(r_beat, bpb_eff);
                r_cin  <= n_cin;
            end
            if (i_cmd.store_phase) begin
                r_phase <= n_phase;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_len <= blk_len;
        end
        if (i_cmd.fix) begin
            r_m     <= n_m;
            r_acc   <= n_acc_first;
            r_beats <= '0;
        end
        if (i_cmd.emit) begin
            r_acc             <= n_acc;
            r_beats           <= r_beats + BCNT_W'(1);
            r_out.beat_offset <= r_acc[FRAC_BITS +: OFS_W];
            r_out.beat_number <= r_beat;
            r_out.click       <= r_playing;
            r_out.accent      <= (r_beat == ACCENT_BEAT);
            r_out.counted_in  <= n_cin;
            r_out.last        <= last_beat;
        end
    end

    always_comb begin
        o_status.in_bar    = i_in.kind;
        o_status.running   = r_running;
        o_status.mod_done  = mod_done;
        o_status.have_beat = have_beat;
        o_status.slot_free = slot_free;
    end

    assign o_out       = r_out;
    assign o_out_valid = r_out_valid;

endmodule

>>> design/bsch_ctrl.sv
// Controller: accepts start-of-bar words and sequences phase reduction, beat emission and phase advance.
module bsch_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  bsch_pkg::t_status i_status,
    output logic              o_in_stall,
    output bsch_pkg::t_cmd    o_cmd
);
    import bsch_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = (r_state != ST_IDLE);
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_status.in_bar) begin
                        o_cmd.accept_bar = 1'b1;
                    end else if (i_status.running) begin
                        o_cmd.load_item = 1'b1;
                        o_cmd.mod_start = 1'b1;
                        o_cmd.mod_src   = SRC_PHASE;
                        n_state         = ST_WRAP;
                    end
                end
            end
            ST_WRAP: begin
                if (i_status.mod_done) begin
                    o_cmd.fix = 1'b1;
                    n_state   = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!i_status.have_beat) begin
                    o_cmd.mod_start = 1'b1;
                    o_cmd.mod_src   = SRC_ADVANCE;
                    n_state         = ST_ADVANCE;
                end else if (i_status.slot_free) begin
                    o_cmd.emit = 1'b1;
                end
            end
            ST_ADVANCE: begin
                if (i_status.mod_done) begin
                    o_cmd.store_phase = 1'b1;
                    n_state           = ST_IDLE;
                end
            end
        endcase
    end

endmodule

>>> design/beat_scheduler_unit.sv
// Metronome beat scheduler: top level joining controller and datapath.
//
// Input channel: one word per audio block (kind 0, num_samples) or per start of
// bar (kind 1, start_beat). Output channel: one word per beat that falls in the
// block, at most 64 per block, the final one of a block marked by last.
// Registers are written through a plain write port; the user must write them
// only while the block is idle, which the block itself does not enforce.
// A start-of-bar word, and an audio block while stopped, are taken without
// stalling the input and give no output. An audio block while running keeps the
// input stalled while the beat phase is reduced modulo the beat length by a
// bit-serial remainder unit, each beat word is then emitted, and the advanced
// phase goes through the same remainder unit again. The first beat word is
// ready once the phase reduction is done. When the receiver stalls, the waiting
// word holds in the output register and emission pauses until it is taken.
// Reset (synchronous, active low) stops the metronome, clears phase, beat
// counter and count-in, and loads four beats per bar and the default beat length.
module beat_scheduler_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  bsch_pkg::t_in_item            i_in,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output bsch_pkg::t_out_item           o_out,
    input  logic                          i_cfg_we,
    input  logic [bsch_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bsch_pkg::SPB_W-1:0]     i_cfg_data
);
    import bsch_pkg::*;

    t_cmd    cmd;
    t_status status;

    bsch_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    bsch_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_stall (i_out_stall),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out       (o_out),
        .o_out_valid (o_out_valid)
    );

endmodule

>>> tb/tb_beat_scheduler_unit.sv
// Self-checking testbench of the metronome beat scheduler with its own beat predictor.
module tb_beat_scheduler_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import bsch_pkg::*;

    typedef longint unsigned u64;

    localparam logic KIND_AUDIO = 1'b0;
    localparam logic KIND_BAR   = 1'b1;

    // Long enough to cover the tail of a block after its last beat word.
    localparam int SETTLE_CYCLES = 150;
    localparam int HOLD_CYCLES   = 400;
    // Worst quiet stretch: remainder pass, a long receiver hold and a phase pause.
    localparam int QUIET_LIMIT   = 5000;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    t_in_item             in_word = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    t_out_item            out_word;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [SPB_W-1:0]     cfg_data = '0;

    // Register copies and beat state of the predictor.
    logic                 sh_running = 1'b0;
    logic                 sh_playing = 1'b0;
    logic [BPB_W-1:0]     sh_bpb = BPB_RESET;
    logic [SPB_W-1:0]     sh_spb = SPB_RESET;
    longint               sh_phase = 0;
    logic [BEAT_W-1:0]    sh_beat = '0;
    logic                 sh_counted = 1'b0;

    t_in_item             pending_q[$];
    t_out_item            beats_due[$];

    int                   errors = 0;
    int                   quiet = 0;
    bit                   in_took = 1'b0;
    bit                   out_took = 1'b0;
    bit                   gaps_on = 1'b1;
    bit                   stall_on = 1'b1;
    int                   gap_left = 0;
    int                   hold_ticket = 0;
    int                   hold_served = 0;
    int                   hold_left = 0;
    int                   run_left = 0;
    bit                   run_stalled = 1'b0;

    beat_scheduler_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_word),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #10 clk = ~clk;
    end

    function automatic logic [SPB_W-1:0] rand_word();
        return SPB_W'({$urandom, $urandom});
    endfunction

    function automatic t_in_item audio_word(int n);
        t_in_item w;
        w.kind        = KIND_AUDIO;
        w.num_samples = NS_W'(n);
        w.start_beat  = BEAT_W'($urandom_range(0, 15));
        return w;
    endfunction

    function automatic t_in_item bar_word(int b);
        t_in_item w;
        w.kind        = KIND_BAR;
        w.num_samples = NS_W'($urandom_range(0, 8191));
        w.start_beat  = BEAT_W'(b);
        return w;
    endfunction

    // Reduce a phase modulo the beat length into [-l/2, l/2).
    function automatic longint fold_phase(longint p, u64 l);
        u64 m;
        if (p < 0) begin
            m = u64'(-p) % l;
            if (m != 0) begin
                m = l - m;
            end
        end else begin
            m = u64'(p) % l;
        end
        if (2 * m >= l) begin
            return -longint'(l - m);
        end
        return longint'(m);
    endfunction

    function automatic void schedule_beats(t_in_item w);
        u64        n;
        u64        l;
        u64        b0;
        u64        q;
        u64        pos;
        int        bpb;
        int        cnt;
        longint    p;
        t_out_item e;
        if (w.kind == KIND_BAR) begin
            sh_counted = 1'b0;
            sh_phase   = 0;
            sh_beat    = w.start_beat;
            return;
        end
        if (!sh_running) begin
            return;
        end
        n = w.num_samples;
        if (n > BLOCK_MAX) begin
            n = BLOCK_MAX;
        end
        l = sh_spb;
        if (l < SPB_MIN) begin
            l = SPB_MIN;
        end
        bpb = sh_bpb;
        if (bpb == 0) begin
            bpb = 1;
        end
        if (bpb > BAR_MAX_BEATS) begin
            bpb = BAR_MAX_BEATS;
        end
        p  = fold_phase(sh_phase, l);
        b0 = (p > 0) ? l - u64'(p) : u64'(-p);
        cnt = 0;
        while (cnt < MAX_BEATS_PER_BLOCK) begin
            pos = (b0 + u64'(cnt) * l) >> FRAC_BITS;
            if (pos >= n) begin
                break;
            end
            if (sh_beat == COUNT_IN_BEAT) begin
                sh_counted = 1'b1;
            end
            e.beat_offset = OFS_W'(pos);
            e.beat_number = sh_beat;
            e.click       = sh_playing;
            e.accent      = (sh_beat == ACCENT_BEAT);
            e.counted_in  = sh_counted;
            e.last        = 1'b0;
            beats_due.push_back(e);
            sh_beat = BEAT_W'((int'(sh_beat) + 1) % bpb);
            cnt++;
        end
        if (cnt > 0) begin
            beats_due[beats_due.size() - 1].last = 1'b1;
        end
        // The phase advances by the whole block, dropped beats included.
        q = (p < 0) ? l - u64'(-p) : u64'(p);
        q = (q + (n << FRAC_BITS)) % l;
        sh_phase = (2 * q >= l) ? -longint'(l - q) : longint'(q);
    endfunction

    task automatic report(string msg);
        if (errors < 40) begin
            $display("%0t mismatch: %s", $time, msg);
        end
        errors++;
    endtask

    task automatic cmp_field(string name, int got, int want);
        if (got != want) begin
            report($sformatf("%s got %0d expected %0d", name, got, want));
        end
    endtask

    task automatic check_beat(t_out_item got);
        t_out_item want;
        if (beats_due.size() == 0) begin
            report($sformatf("beat word at offset %0d with none expected", got.beat_offset));
            return;
        end
        want = beats_due.pop_front();
        cmp_field("beat_offset", got.beat_offset, want.beat_offset);
        cmp_field("beat_number", got.beat_number, want.beat_number);
        cmp_field("click", got.click, want.click);
        cmp_field("accent", got.accent, want.accent);
        cmp_field("counted_in", got.counted_in, want.counted_in);
        cmp_field("last", got.last, want.last);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [SPB_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_RUNNING: begin
                sh_running = val[0];
                if (!val[0]) begin
                    sh_phase   = 0;
                    sh_beat    = '0;
                    sh_counted = 1'b0;
                end
            end
            CFG_PLAYING: sh_playing = val[0];
            CFG_BPB:     sh_bpb = val[BPB_W-1:0];
            CFG_SPB:     sh_spb = val;
            default: ;
        endcase
    endtask

    task automatic drain();
        while (pending_q.size() != 0 || in_valid) @(posedge clk);
        while (beats_due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Sender: one word in flight, fed from the pending queue.
    always @(negedge clk) begin : drive_in
        logic     nv;
        t_in_item nw;
        nv = in_valid;
        nw = in_word;
        if (!rst_n) begin
            nv = 1'b0;
        end else begin
            if (in_valid && in_took) begin
                nv = 1'b0;
                gap_left = gaps_on ? pick_gap() : 0;
            end
            if (!nv) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_q.size() != 0) begin
                    nw = pending_q.pop_front();
                    nv = 1'b1;
                end
            end
        end
        in_valid <= nv;
        in_word  <= nw;
    end

    // Receiver: random stall runs, or a long hold when one is requested.
    always @(negedge clk) begin
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else if (hold_served != hold_ticket) begin
            hold_served = hold_ticket;
            hold_left   = HOLD_CYCLES;
            out_stall  <= 1'b1;
        end else if (!stall_on) begin
            out_stall <= 1'b0;
        end else begin
            if (run_left == 0) begin
                run_stalled = !run_stalled;
                if (!run_stalled) begin
                    run_left = $urandom_range(1, 6);
                end else if ($urandom_range(0, 99) < 88) begin
                    run_left = $urandom_range(1, 3);
                end else begin
                    run_left = $urandom_range(20, 60);
                end
            end
            run_left--;
            out_stall <= run_stalled;
        end
    end

    always @(posedge clk) begin
        if (!rst_n) begin
            in_took = 1'b0;
        end else begin
            in_took  = in_valid && !in_stall;
            out_took = out_valid && !out_stall;
            if (in_took) begin
                schedule_beats(in_word);
            end
            if (out_took) begin
                check_beat(out_word);
            end
            if (in_took || out_took) begin
                quiet = 0;
            end else if (++quiet >= QUIET_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial begin
        int               useful;
        int               total;
        int               r;
        bit               run_on;
        logic [SPB_W-1:0] word;
        logic [SPB_W-1:0] spb_val;
        logic [BPB_W-1:0] bpb_val;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Stopped after reset: audio gives nothing, a start of bar still loads the counter.
        @(posedge clk);
        pending_q.push_back(audio_word(4096));
        pending_q.push_back(bar_word(2));
        drain();

        write_reg(CFG_RUNNING, 1);
        write_reg(CFG_PLAYING, 1);
        write_reg(CFG_BPB, 4);
        write_reg(CFG_SPB, SPB_MIN);
        @(posedge clk);
        // Shortest beat over a full block fills the per-block cap exactly.
        pending_q.push_back(audio_word(4096));
        pending_q.push_back(audio_word(0));
        pending_q.push_back(audio_word(8191));
        pending_q.push_back(audio_word(1));
        pending_q.push_back(audio_word(100));
        pending_q.push_back(bar_word(15));
        pending_q.push_back(audio_word(200));
        pending_q.push_back(bar_word(0));
        pending_q.push_back(audio_word(63));
        drain();

        // Beat length below the floor and a zero bar length.
        write_reg(CFG_SPB, 5);
        write_reg(CFG_BPB, 0);
        write_reg(CFG_PLAYING, 0);
        @(posedge clk);
        pending_q.push_back(audio_word(4096));
        pending_q.push_back(audio_word(37));
        pending_q.push_back(audio_word(1000));
        drain();

        // Longest beat and a bar length above the maximum.
        write_reg(CFG_BPB, 31);
        write_reg(CFG_SPB, {SPB_W{1'b1}});
        @(posedge clk);
        pending_q.push_back(bar_word(0));
        pending_q.push_back(audio_word(4096));
        pending_q.push_back(audio_word(4096));
        drain();

        // Tempo change: the carried phase is folded into the new beat length.
        write_reg(CFG_SPB, SPB_W'((1000 << FRAC_BITS) + 12345));
        @(posedge clk);
        pending_q.push_back(audio_word(4096));
        pending_q.push_back(audio_word(3000));
        pending_q.push_back(bar_word(7));
        pending_q.push_back(audio_word(2500));
        drain();

        write_reg(CFG_RUNNING, 0);
        @(posedge clk);
        pending_q.push_back(audio_word(4096));
        pending_q.push_back(bar_word(1));
        drain();
        write_reg(CFG_RUNNING, 1);
        write_reg(CFG_BPB, 16);
        write_reg(CFG_SPB, SPB_MIN + 1);
        @(posedge clk);
        pending_q.push_back(audio_word(500));
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            run_on = (ph == 0) || ($urandom_range(0, 9) != 0);
            case ($urandom_range(0, 5))
                0:       bpb_val = 0;
                1:       bpb_val = 1;
                2:       bpb_val = 16;
                3:       bpb_val = BPB_W'($urandom_range(17, 31));
                default: bpb_val = BPB_W'($urandom_range(2, 15));
            endcase
            r = $urandom_range(0, 19);
            if (ph == 0) begin
                spb_val = SPB_MIN;
            end else if (r < 14) begin
                spb_val = SPB_W'((u64'($urandom_range(64, 1500)) << FRAC_BITS)
                                 | u64'($urandom_range(0, 65535)));
            end else if (r < 17) begin
                spb_val = rand_word();
            end else begin
                spb_val = SPB_W'($urandom_range(0, 4194303));
            end
            // Bits above each register's width ride along at random.
            word = rand_word();
            word[0] = run_on;
            write_reg(CFG_RUNNING, word);
            word = rand_word();
            write_reg(CFG_PLAYING, word);
            word = rand_word();
            word[BPB_W-1:0] = bpb_val;
            write_reg(CFG_BPB, word);
            write_reg(CFG_SPB, spb_val);

            gaps_on  = (ph != 0) && ($urandom_range(0, 2) != 0);
            stall_on = (ph != 0) && ($urandom_range(0, 2) != 0);
            @(posedge clk);
            if (ph == 0) begin
                // Long receiver hold with the sender pressing on fills the block up.
                hold_ticket++;
            end
            useful = 0;
            total  = 0;
            while (run_on ? useful < 48 : total < 15) begin
                r = $urandom_range(0, 99);
                if (r < 12) begin
                    pending_q.push_back(bar_word($urandom_range(0, 15)));
                end else if (r < 17) begin
                    pending_q.push_back(audio_word(0));
                end else if (r < 27) begin
                    pending_q.push_back(audio_word($urandom_range(4097, 8191)));
                end else if (r < 47) begin
                    pending_q.push_back(audio_word($urandom_range(1, 64)));
                end else begin
                    pending_q.push_back(audio_word($urandom_range(1, 4096)));
                end
                useful++;
                total++;
            end
            drain();
        end

        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
